### rtl/assert_macros.svh
// Assertion helper macros shared by the remap address RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

### rtl/rdra_pkg.sv
// Shared types and constants for the radial distortion remap address block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rdra_pkg;

   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = COORD_BITS + 1;
   localparam int FRAC_BITS  = 16;
   localparam int COEF_BITS  = 18;
   localparam int SCALE_BITS = 21;
   localparam int DX_BITS    = COORD_BITS + 1;
   localparam int SUMSQ_BITS = 2 * COORD_BITS + 1;
   localparam int ROOT_BITS  = 29;
   localparam int DIV_BITS   = 29;
   localparam int INDEX_BITS = 2 * COORD_BITS;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = COEF_BITS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CUBIC_COEFF  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SQUARE_COEFF = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LINEAR_COEFF = 3'd4;

   typedef struct packed {
      logic [SIZE_BITS-1:0]          w;
      logic [SIZE_BITS-1:0]          h;
      logic [COORD_BITS-1:0]         d;
      logic [COORD_BITS-2:0]         cx;
      logic [COORD_BITS-2:0]         cy;
      logic signed [COEF_BITS-1:0]   a;
      logic signed [COEF_BITS-1:0]   b;
      logic signed [COEF_BITS-1:0]   c;
      logic signed [SCALE_BITS-1:0]  scale;
   } cfg_type;

   typedef struct packed {
      logic signed [DX_BITS-1:0] dx;
      logic signed [DX_BITS-1:0] dy;
   } side_type;

endpackage

### rtl/radial_distortion_remap_address_top.sv
// Radial distortion remap address generator, top level.
// Depends on rdra_pkg, rdra_cfg, rdra_isqrt, rdra_div, rdra_poly, assert_macros.svh.
//
// Usage:
//  - req_ channel: one destination pixel per request, req_tdata = {dest_y, dest_x}.
//  - rsp_ channel: one result per request, in order: rsp_tdata holds
//    source_x, source_y and the linear source index, rsp_tuser the
//    out-of-bounds flag.
//  - csr_ port: write image size and the three Q.16 coefficients while no
//    request is in flight; writes to unknown indexes are dropped.
//  - Pipeline: two input registers, 29-stage square root, 29-stage radius divider,
//    8-stage polynomial, 29-stage x and y dividers side by side, two output registers.
//  - Throughput: one request per cycle, back to back, while the receiver does not stall.
//  - Reset clears all valid bits and loads the default geometry (640 x 480)
//    and coefficients; the block accepts requests the cycle after reset.
//  - When the receiver stalls with a result waiting, the whole pipeline holds
//    and req_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module radial_distortion_remap_address_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [11:0] dest_x, [23:12] dest_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [11:0] source_x, [23:12] source_y, [47:24] source_index
   output logic [0:0]  rsp_tuser,   // [0] out_of_bounds
   input  logic        csr_we,
   input  logic [rdra_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rdra_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CB = rdra_pkg::COORD_BITS;
   localparam int DB = rdra_pkg::DIV_BITS;

   rdra_pkg::cfg_type  cfg;
   logic               en;

   logic               v1_ff, v2_ff, vc_ff, out_valid_ff;
   rdra_pkg::side_type side1_ff, side2_ff, side_in;
   logic [rdra_pkg::SUMSQ_BITS-1:0] s_ff;
   logic signed [25:0] sqx, sqy;

   logic               sq_valid, rd_valid, pl_valid, cx_valid, cy_valid;
   rdra_pkg::side_type sq_side, rd_side, pl_side, cx_side, cy_side;
   logic [rdra_pkg::ROOT_BITS-1:0] root, rq;
   logic               rd_rem_nz, qx_rem_nz, qy_rem_nz;
   logic [DB-1:0]      den, numx, numy, qx, qy;
   logic [CB-1:0]      adx, ady;

   logic signed [31:0] sx_raw, sy_raw;
   logic [CB-1:0]      sx_in, sy_in, sx_ff, sy_ff, osx_ff, osy_ff;
   logic               oob_in, oob_ff, out_oob_ff;
   logic [rdra_pkg::INDEX_BITS-1:0] idx_ff;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   rdra_cfg u_cfg (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .cfg
   );

   // offsets from the centre
   always_comb begin
      side_in.dx = $signed({1'b0, req_tdata[CB-1:0]}) - $signed({2'b00, cfg.cx});
      side_in.dy = $signed({1'b0, req_tdata[2*CB-1:CB]}) - $signed({2'b00, cfg.cy});
      sqx = side1_ff.dx * side1_ff.dx;
      sqy = side1_ff.dy * side1_ff.dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side_in;
         side2_ff <= side1_ff;
         s_ff     <= rdra_pkg::SUMSQ_BITS'(sqx) + rdra_pkg::SUMSQ_BITS'(sqy);
      end
   end

   rdra_isqrt u_isqrt (
      .clock, .reset, .en,
      .in_valid (v2_ff), .s (s_ff), .in_side (side2_ff),
      .out_valid (sq_valid), .root (root), .out_side (sq_side)
   );

   // normalized radius r = floor(t / d), Q.16
   rdra_div u_rdiv (
      .clock, .reset, .en,
      .in_valid (sq_valid), .num (root), .den (DB'(cfg.d)), .in_side (sq_side),
      .out_valid (rd_valid), .quo (rq), .rem_nz (rd_rem_nz), .out_side (rd_side)
   );

   rdra_poly u_poly (
      .clock, .reset, .en, .cfg,
      .in_valid (rd_valid), .r (rq), .in_side (rd_side),
      .out_valid (pl_valid), .den (den), .out_side (pl_side)
   );

   always_comb begin
      adx  = pl_side.dx[rdra_pkg::DX_BITS-1] ? CB'(-pl_side.dx) : CB'(pl_side.dx);
      ady  = pl_side.dy[rdra_pkg::DX_BITS-1] ? CB'(-pl_side.dy) : CB'(pl_side.dy);
      numx = DB'({adx, 16'h0000});
      numy = DB'({ady, 16'h0000});
   end

   rdra_div u_xdiv (
      .clock, .reset, .en,
      .in_valid (pl_valid), .num (numx), .den (den), .in_side (pl_side),
      .out_valid (cx_valid), .quo (qx), .rem_nz (qx_rem_nz), .out_side (cx_side)
   );

   rdra_div u_ydiv (
      .clock, .reset, .en,
      .in_valid (pl_valid), .num (numy), .den (den), .in_side (pl_side),
      .out_valid (cy_valid), .quo (qy), .rem_nz (qy_rem_nz), .out_side (cy_side)
   );

   // floor the signed quotient, add the centre, clamp into the image
   always_comb begin
      sx_raw = $signed({1'b0, 20'h0, cfg.cx}) + (cx_side.dx[rdra_pkg::DX_BITS-1]
               ? -$signed({3'b000, qx}) - $signed({31'h0, qx_rem_nz})
               : $signed({3'b000, qx}));
      sy_raw = $signed({1'b0, 20'h0, cfg.cy}) + (cy_side.dy[rdra_pkg::DX_BITS-1]
               ? -$signed({3'b000, qy}) - $signed({31'h0, qy_rem_nz})
               : $signed({3'b000, qy}));
      oob_in = 1'b0;
      sx_in  = sx_raw[CB-1:0];
      sy_in  = sy_raw[CB-1:0];
      if (sx_raw < 0) begin
         sx_in  = '0;
         oob_in = 1'b1;
      end else if (sx_raw > $signed(32'(cfg.w) - 32'sd1)) begin
         sx_in  = CB'(cfg.w - 13'd1);
         oob_in = 1'b1;
      end
      if (sy_raw < 0) begin
         sy_in  = '0;
         oob_in = 1'b1;
      end else if (sy_raw > $signed(32'(cfg.h) - 32'sd1)) begin
         sy_in  = CB'(cfg.h - 13'd1);
         oob_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vc_ff        <= cx_valid && cy_valid;
         out_valid_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff      <= sx_in;
         sy_ff      <= sy_in;
         oob_ff     <= oob_in;
         osx_ff     <= sx_ff;
         osy_ff     <= sy_ff;
         out_oob_ff <= oob_ff;
         idx_ff     <= rdra_pkg::INDEX_BITS'(25'(sy_ff) * 25'(cfg.w) + 25'(sx_ff));
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {idx_ff, osy_ff, osx_ff};
   assign rsp_tuser  = out_oob_ff;

   `ASSERT_IMPLY(a_reset_clears_rsp, clock, reset, $past(reset), !rsp_tvalid)
   `ASSERT_ALWAYS(a_div_lanes_aligned, clock, reset, cx_valid == cy_valid)
   `ASSERT_IMPLY(a_rdiv_den_nonzero, clock, reset, sq_valid, cfg.d != '0)

endmodule

### rtl/rdra_cfg.sv
// Configuration registers and the image geometry derived from them.
// Depends on rdra_pkg.
`timescale 1ns / 1ps

module rdra_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rdra_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [rdra_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output rdra_pkg::cfg_type                   cfg
);

   logic [rdra_pkg::SIZE_BITS-1:0]        width_ff, height_ff, w, h, wh_min;
   logic signed [rdra_pkg::COEF_BITS-1:0] cubic_ff, square_ff, linear_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         cubic_ff  <= -18'sd506;
         square_ff <= 18'sd1752;
         linear_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rdra_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[rdra_pkg::SIZE_BITS-1:0];
            rdra_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[rdra_pkg::SIZE_BITS-1:0];
            rdra_pkg::CSR_CUBIC_COEFF:  cubic_ff  <= $signed(csr_wdata);
            rdra_pkg::CSR_SQUARE_COEFF: square_ff <= $signed(csr_wdata);
            rdra_pkg::CSR_LINEAR_COEFF: linear_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // saturate sizes to 2 .. 4096
   always_comb begin
      w = width_ff;
      if (width_ff < 13'd2) w = 13'd2;
      else if (width_ff[12] && (|width_ff[11:0])) w = 13'h1000;
      h = height_ff;
      if (height_ff < 13'd2) h = 13'd2;
      else if (height_ff[12] && (|height_ff[11:0])) h = 13'h1000;
      wh_min = (w < h) ? w : h;
   end

   always_comb begin
      cfg.w     = w;
      cfg.h     = h;
      cfg.d     = wh_min[12:1];
      cfg.cx    = 11'((w - 13'd1) >> 1);
      cfg.cy    = 11'((h - 13'd1) >> 1);
      cfg.a     = cubic_ff;
      cfg.b     = square_ff;
      cfg.c     = linear_ff;
      cfg.scale = 21'sd65536 - 21'(cubic_ff) - 21'(square_ff) - 21'(linear_ff);
   end

endmodule

### rtl/rdra_isqrt.sv
// Pipelined integer square root of (s << 32), one result bit per stage.
// Depends on rdra_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdra_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [rdra_pkg::SUMSQ_BITS-1:0]   s,
   input  rdra_pkg::side_type                in_side,
   output logic                              out_valid,
   output logic [rdra_pkg::ROOT_BITS-1:0]    root,
   output rdra_pkg::side_type                out_side
);

   localparam int N    = rdra_pkg::ROOT_BITS;
   localparam int OPW  = rdra_pkg::SUMSQ_BITS + 1;
   localparam int REMW = N + 1;

   logic                valid_ff [N];
   logic [REMW-1:0]     rem_ff   [N];
   logic [N-1:0]        root_ff  [N];
   logic [OPW-1:0]      opnd_ff  [N];
   rdra_pkg::side_type  side_ff  [N];

   logic [REMW-1:0]     rem_src  [N];
   logic [N-1:0]        root_src [N];
   logic [OPW-1:0]      opnd_src [N];
   logic [REMW+1:0]     rs       [N];
   logic [REMW+1:0]     tr       [N];
   logic                ge       [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign rem_src[k]  = '0;
         assign root_src[k] = '0;
         assign opnd_src[k] = {1'b0, s};
      end else begin : g_next
         assign rem_src[k]  = rem_ff[k-1];
         assign root_src[k] = root_ff[k-1];
         assign opnd_src[k] = opnd_ff[k-1];
      end
      // bring down the next pair of radicand bits and try root*4+1
      assign rs[k] = {rem_src[k], opnd_src[k][OPW-1:OPW-2]};
      assign tr[k] = {1'b0, root_src[k], 2'b01};
      assign ge[k] = (rs[k] >= tr[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-((k == 0) ? 0 : 1)];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge[k] ? REMW'(rs[k] - tr[k]) : REMW'(rs[k]);
            root_ff[k] <= {root_src[k][N-2:0], ge[k]};
            opnd_ff[k] <= {opnd_src[k][OPW-3:0], 2'b00};
            side_ff[k] <= (k == 0) ? in_side : side_ff[k-((k == 0) ? 0 : 1)];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign root      = root_ff[N-1];
   assign out_side  = side_ff[N-1];

   `ASSERT_IMPLY(a_sqrt_rem_bound, clock, reset, valid_ff[N-1],
                 rem_ff[N-1] <= (REMW'(root_ff[N-1]) << 1))

endmodule

### rtl/rdra_div.sv
// Pipelined unsigned restoring divider, 29 by 29 bits, one quotient bit per stage.
// Depends on rdra_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdra_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [rdra_pkg::DIV_BITS-1:0]    num,
   input  logic [rdra_pkg::DIV_BITS-1:0]    den,
   input  rdra_pkg::side_type               in_side,
   output logic                             out_valid,
   output logic [rdra_pkg::DIV_BITS-1:0]    quo,
   output logic                             rem_nz,
   output rdra_pkg::side_type               out_side
);

   localparam int N = rdra_pkg::DIV_BITS;

   logic                valid_ff [N];
   logic [N-1:0]        rem_ff   [N];
   logic [N-1:0]        nq_ff    [N];
   logic [N-1:0]        den_ff   [N];
   rdra_pkg::side_type  side_ff  [N];

   logic [N-1:0]        rem_src  [N];
   logic [N-1:0]        nq_src   [N];
   logic [N-1:0]        den_src  [N];
   logic [N:0]          rs       [N];
   logic                ge       [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign rem_src[k] = '0;
         assign nq_src[k]  = num;
         assign den_src[k] = den;
      end else begin : g_next
         assign rem_src[k] = rem_ff[k-1];
         assign nq_src[k]  = nq_ff[k-1];
         assign den_src[k] = den_ff[k-1];
      end
      // shift in the next dividend bit; quotient bits fill the low end
      assign rs[k] = {rem_src[k], nq_src[k][N-1]};
      assign ge[k] = (rs[k] >= {1'b0, den_src[k]});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-((k == 0) ? 0 : 1)];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge[k] ? N'(rs[k] - {1'b0, den_src[k]}) : N'(rs[k]);
            nq_ff[k]   <= {nq_src[k][N-2:0], ge[k]};
            den_ff[k]  <= den_src[k];
            side_ff[k] <= (k == 0) ? in_side : side_ff[k-((k == 0) ? 0 : 1)];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign quo       = nq_ff[N-1];
   assign rem_nz    = |rem_ff[N-1];
   assign out_side  = side_ff[N-1];

   `ASSERT_IMPLY(a_div_rem_lt_den, clock, reset, valid_ff[N-1] && (|den_ff[N-1]),
                 rem_ff[N-1] < den_ff[N-1])

endmodule

### rtl/rdra_poly.sv
// Horner evaluation of a*r^3 + b*r^2 + c*r + scale in Q.16, eight stages,
// ending in the clipped nonzero divisor magnitude. Depends on rdra_pkg.
`timescale 1ns / 1ps

module rdra_poly (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  rdra_pkg::cfg_type                cfg,
   input  logic                             in_valid,
   input  logic [rdra_pkg::ROOT_BITS-1:0]   r,
   input  rdra_pkg::side_type               in_side,
   output logic                             out_valid,
   output logic [rdra_pkg::DIV_BITS-1:0]    den,
   output rdra_pkg::side_type               out_side
);

   localparam int NS = 8;
   localparam int RB = rdra_pkg::ROOT_BITS;

   logic               valid_ff [NS];
   rdra_pkg::side_type side_ff  [NS];
   logic [RB-1:0]      r1_ff, r2_ff, r3_ff, r4_ff;
   logic               neg1_ff, neg3_ff, neg5_ff, neg6_ff;
   logic [46:0]        m1_ff;
   logic signed [32:0] acc1_ff;
   logic [60:0]        m2_ff;
   logic signed [46:0] acc2_ff;
   logic [51:0]        pl_ff, ph_ff;
   logic [74:0]        m3_ff;
   logic signed [60:0] acc3_ff;
   logic [RB-1:0]      den_ff;

   logic [17:0]        ma_in;
   logic signed [32:0] p1_in;
   logic [31:0]        u1_in;
   logic signed [46:0] p2_in;
   logic [45:0]        u2_in;
   logic signed [60:0] p3_in;
   logic [60:0]        u3_in;
   logic [RB-1:0]      den_in;

   always_comb begin
      ma_in = cfg.a[17] ? 18'(-cfg.a) : 18'(cfg.a);
      p1_in = $signed({2'b00, m1_ff[46:16]});
      u1_in = acc1_ff[32] ? 32'(-acc1_ff) : 32'(acc1_ff);
      p2_in = $signed({2'b00, m2_ff[60:16]});
      u2_in = acc2_ff[46] ? 46'(-acc2_ff) : 46'(acc2_ff);
      p3_in = $signed({2'b00, m3_ff[74:16]});
      u3_in = acc3_ff[60] ? 61'(-acc3_ff) : 61'(acc3_ff);
      // a zero polynomial counts as one LSB; anything past 2^28 divides to 0 or -1
      if (u3_in == '0) den_in = RB'(1);
      else if (u3_in >= 61'(1 << 28)) den_in = RB'(1 << 28);
      else den_in = u3_in[RB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < NS; k++) side_ff[k] <= side_ff[k-1];
         // stage 1: |a| * r
         m1_ff   <= 47'(ma_in) * 47'(r);
         neg1_ff <= cfg.a[17];
         r1_ff   <= r;
         // stage 2: + b
         acc1_ff <= (neg1_ff ? -p1_in : p1_in) + 33'(cfg.b);
         r2_ff   <= r1_ff;
         // stage 3: |acc| * r
         m2_ff   <= 61'(u1_in) * 61'(r2_ff);
         neg3_ff <= acc1_ff[32];
         r3_ff   <= r2_ff;
         // stage 4: + c
         acc2_ff <= (neg3_ff ? -p2_in : p2_in) + 47'(cfg.c);
         r4_ff   <= r3_ff;
         // stage 5: |acc| * r in two partial products
         pl_ff   <= 52'(u2_in[22:0]) * 52'(r4_ff);
         ph_ff   <= 52'(u2_in[45:23]) * 52'(r4_ff);
         neg5_ff <= acc2_ff[46];
         // stage 6: merge partial products
         m3_ff   <= (75'(ph_ff) << 23) + 75'(pl_ff);
         neg6_ff <= neg5_ff;
         // stage 7: + scale
         acc3_ff <= (neg6_ff ? -p3_in : p3_in) + 61'(cfg.scale);
         // stage 8: divisor magnitude
         den_ff  <= den_in;
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign den       = den_ff;
   assign out_side  = side_ff[NS-1];

endmodule

### sim/tb.sv
// Self-checking bench for the radial distortion remap address generator.
// Depends on rdra_pkg and radial_distortion_remap_address_top; predicts every result in-line.
`timescale 1ns / 1ps

module tb;

   localparam longint SAT_MAX   = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam int     LIMIT     = 1000000;
   localparam int     RAND_ITEMS = 192;
   localparam int     IDXW      = rdra_pkg::CSR_IDX_BITS;
   localparam int     DATW      = rdra_pkg::CSR_DATA_BITS;
   localparam int     FRAC      = rdra_pkg::FRAC_BITS;

   typedef struct {
      logic [11:0] sx;
      logic [11:0] sy;
      logic [23:0] idx;
      logic        oob;
   } remap_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [IDXW-1:0] csr_index = '0;
   logic [DATW-1:0] csr_wdata = '0;

   // register mirror
   logic [12:0] geo_w = 13'd640;
   logic [12:0] geo_h = 13'd480;
   longint      coef_a = -506, coef_b = 1752, coef_c = 0;

   logic [23:0] pending_req[$];
   remap_type   expected_q[$];
   int          errors = 0;
   int          cycles = 0;
   bit          req_fired = 0, rsp_fired = 0;
   bit          no_idle = 0;
   int          req_gap = 0, rsp_stall = 0;

   radial_distortion_remap_address_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clip62(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < -SAT_MAX) return -SAT_MAX;
      return v;
   endfunction

   // magnitude times radius, truncated, sign restored, saturated
   function automatic longint horner_mul(longint acc, longint unsigned r);
      bit neg;
      longint unsigned u, uh, ul, m;
      neg = acc < 0;
      u = neg ? longint'(-acc) : acc;
      uh = u >> FRAC;
      ul = u & 64'hFFFF;
      if (uh != 0 && r > longint'(SAT_MAX) / uh) m = SAT_MAX;
      else begin
         m = uh * r + ((ul * r) >> FRAC);
         if (m > SAT_MAX) m = SAT_MAX;
      end
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic remap_type remap_predict(logic [11:0] px, logic [11:0] py);
      remap_type res;
      longint w, h, d, cx, cy, dx, dy, one, scale, acc, den, sx, sy, q;
      longint unsigned s, n, root, bitv, r;
      bit oob;
      w = (geo_w < 2) ? 2 : (geo_w > 4096) ? 4096 : geo_w;
      h = (geo_h < 2) ? 2 : (geo_h > 4096) ? 4096 : geo_h;
      d = ((w < h) ? w : h) / 2;
      cx = (w - 1) / 2;
      cy = (h - 1) / 2;
      dx = longint'(px) - cx;
      dy = longint'(py) - cy;
      s = dx * dx + dy * dy;
      n = s << 32;
      root = 0;
      bitv = 64'h1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else root >>= 1;
         bitv >>= 2;
      end
      r = (root << FRAC) / (longint'(d) << 16);
      one = 64'h1 << FRAC;
      scale = one - coef_a - coef_b - coef_c;
      acc = clip62(horner_mul(coef_a, r) + coef_b);
      acc = clip62(horner_mul(acc, r) + coef_c);
      acc = clip62(horner_mul(acc, r) + scale);
      den = acc < 0 ? -acc : acc;
      if (den == 0) den = 1;
      oob = 0;
      q = (dx * one) / den;
      if ((dx * one) % den != 0 && dx < 0) q--;
      sx = cx + q;
      q = (dy * one) / den;
      if ((dy * one) % den != 0 && dy < 0) q--;
      sy = cy + q;
      if (sx < 0) begin sx = 0; oob = 1; end
      if (sx > w - 1) begin sx = w - 1; oob = 1; end
      if (sy < 0) begin sy = 0; oob = 1; end
      if (sy > h - 1) begin sy = h - 1; oob = 1; end
      res.sx = sx[11:0];
      res.sy = sy[11:0];
      res.idx = 24'(sy * w + sx);
      res.oob = oob;
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
      errors++;
   endtask

   // monitor: record accepted requests, check accepted results
   always @(posedge clock) begin
      remap_type want;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
      req_fired = !reset && req_tvalid && req_tready;
      rsp_fired = !reset && rsp_tvalid && rsp_tready;
      if (rsp_fired) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected rsp_tvalid", 1, 0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[11:0] !== want.sx) report_mismatch("source_x", rsp_tdata[11:0], want.sx);
            if (rsp_tdata[23:12] !== want.sy)
               report_mismatch("source_y", rsp_tdata[23:12], want.sy);
            if (rsp_tdata[47:24] !== want.idx)
               report_mismatch("source_index", rsp_tdata[47:24], want.idx);
            if (rsp_tuser[0] !== want.oob)
               report_mismatch("out_of_bounds", rsp_tuser[0], want.oob);
         end
      end
      if (req_fired)
         expected_q.insert(expected_q.size(),
                           remap_predict(req_tdata[11:0], req_tdata[23:12]));
   end

   // driver: hold a request until taken, then wait out a drawn gap
   always @(negedge clock) begin
      logic        nv;
      logic [23:0] nd;
      nv = req_tvalid;
      nd = req_tdata;
      if (!reset && !(req_tvalid && !req_fired)) begin
         nv = 1'b0;
         if (req_gap > 0) req_gap--;
         else if (pending_req.size() != 0) begin
            nd = pending_req.pop_front();
            nv = 1'b1;
            req_gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         end
      end
      req_tvalid <= nv;
      req_tdata <= nd;
   end

   // receiver: stall for a drawn count after every result
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else begin
         if (rsp_fired)
            rsp_stall = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   task automatic csr_write(logic [IDXW-1:0] idx, logic [DATW-1:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         rdra_pkg::CSR_IMAGE_WIDTH:  geo_w = val[12:0];
         rdra_pkg::CSR_IMAGE_HEIGHT: geo_h = val[12:0];
         rdra_pkg::CSR_CUBIC_COEFF:  coef_a = longint'($signed(val));
         rdra_pkg::CSR_SQUARE_COEFF: coef_b = longint'($signed(val));
         rdra_pkg::CSR_LINEAR_COEFF: coef_c = longint'($signed(val));
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [DATW-1:0] pick_size();
      logic [12:0] v;
      case ($urandom_range(0, 5))
         0: v = 13'd2;
         1: v = 13'd4096;
         2: v = 13'($urandom_range(2, 64));
         default: v = 13'($urandom_range(2, 4096));
      endcase
      return {5'($urandom), v};
   endfunction

   function automatic logic [DATW-1:0] pick_coeff();
      case ($urandom_range(0, 7))
         0: return 18'h20000;
         1: return 18'h1FFFF;
         2: return 18'($urandom);
         default: return 18'($signed($urandom_range(0, 16000)) - 8000);
      endcase
   endfunction

   task automatic queue_point(int x, int y);
      pending_req.insert(pending_req.size(), {12'(y), 12'(x)});
   endtask

   initial begin
      int w, h;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults: corners, centre (zero radius), edges, field extremes
      queue_point(0, 0);
      queue_point(4095, 4095);
      queue_point(0, 4095);
      queue_point(4095, 0);
      queue_point(319, 239);
      queue_point(639, 479);
      queue_point(640, 480);
      queue_point(2730, 1365);
      queue_point(1365, 2730);
      queue_point(320, 0);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase > 0) begin
            while (!(pending_req.size() == 0 && !req_tvalid && expected_q.size() == 0))
               @(negedge clock);
            no_idle = (phase == 5);
            // unknown indexes must be dropped
            csr_write(IDXW'(5 + phase % 3), 18'($urandom));
            case (phase)
               1: begin
                  csr_write(rdra_pkg::CSR_IMAGE_WIDTH, 18'd2);
                  csr_write(rdra_pkg::CSR_IMAGE_HEIGHT, 18'd2);
                  csr_write(rdra_pkg::CSR_CUBIC_COEFF, pick_coeff());
                  csr_write(rdra_pkg::CSR_SQUARE_COEFF, pick_coeff());
                  csr_write(rdra_pkg::CSR_LINEAR_COEFF, pick_coeff());
               end
               2: begin
                  csr_write(rdra_pkg::CSR_IMAGE_WIDTH, 18'd4096);
                  csr_write(rdra_pkg::CSR_IMAGE_HEIGHT, 18'd4096);
                  csr_write(rdra_pkg::CSR_CUBIC_COEFF, 18'h1FFFF);
                  csr_write(rdra_pkg::CSR_SQUARE_COEFF, 18'h20000);
                  csr_write(rdra_pkg::CSR_LINEAR_COEFF, 18'h1FFFF);
                  queue_point(2047, 2047);
                  queue_point(4095, 4095);
               end
               3: begin
                  // out-of-range sizes saturate
                  csr_write(rdra_pkg::CSR_IMAGE_WIDTH, 18'h3FFFF);
                  csr_write(rdra_pkg::CSR_IMAGE_HEIGHT, 18'h3E000);
                  csr_write(rdra_pkg::CSR_CUBIC_COEFF, 18'h20000);
                  csr_write(rdra_pkg::CSR_SQUARE_COEFF, 18'h20000);
                  csr_write(rdra_pkg::CSR_LINEAR_COEFF, 18'h20000);
               end
               4: begin
                  // scale of zero: the polynomial vanishes at the centre
                  csr_write(rdra_pkg::CSR_IMAGE_WIDTH, 18'd1);
                  csr_write(rdra_pkg::CSR_IMAGE_HEIGHT, 18'd100);
                  csr_write(rdra_pkg::CSR_CUBIC_COEFF, 18'd0);
                  csr_write(rdra_pkg::CSR_SQUARE_COEFF, 18'd0);
                  csr_write(rdra_pkg::CSR_LINEAR_COEFF, 18'd65536);
                  queue_point(0, 49);
                  queue_point(1, 49);
                  queue_point(0, 50);
               end
               default: begin
                  csr_write(rdra_pkg::CSR_IMAGE_WIDTH, pick_size());
                  csr_write(rdra_pkg::CSR_IMAGE_HEIGHT, pick_size());
                  csr_write(rdra_pkg::CSR_CUBIC_COEFF, pick_coeff());
                  csr_write(rdra_pkg::CSR_SQUARE_COEFF, pick_coeff());
                  csr_write(rdra_pkg::CSR_LINEAR_COEFF, pick_coeff());
               end
            endcase
         end
         w = (geo_w < 2) ? 2 : (geo_w > 4096) ? 4096 : geo_w;
         h = (geo_h < 2) ? 2 : (geo_h > 4096) ? 4096 : geo_h;
         for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(0, 4) == 0)
               pending_req.insert(pending_req.size(), 24'($urandom));
            else queue_point($urandom_range(0, w - 1), $urandom_range(0, h - 1));
         end
      end

      while (!(pending_req.size() == 0 && !req_tvalid && expected_q.size() == 0))
         @(negedge clock);
      repeat (120) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
